@@ sv/wall_follow_pd_speed_defines.svh @@
// Assertion macros shared by the wall follower checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef WALL_FOLLOW_PD_SPEED_DEFINES_SVH
`define WALL_FOLLOW_PD_SPEED_DEFINES_SVH

// same-cycle implication
`define WFPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wfpd assertion failed");

// next-cycle implication
`define WFPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wfpd assertion failed");

`endif

@@ sv/wfpd_pkg.sv @@
// Shared types and constants for the wall follower PD speed block.
// No dependencies.
`timescale 1ns / 1ps
package wfpd_pkg;

  // echo_us / 58 as (echo_us * 72316) >> 22, exact over 16 bits
  localparam logic [16:0] CM_RECIP   = 17'd72316;
  localparam int          CM_SHIFT   = 22;
  // first echo that maps above 250 cm
  localparam logic [15:0] ECHO_LIMIT = 16'd14558;

  // x / 3 as (x * 683) >> 11, exact for x <= 750
  localparam logic [9:0]  DIV3_RECIP = 10'd683;
  localparam int          DIV3_SHIFT = 11;

  localparam logic [2:0]  PHASE_D1_DONE = 3'd2;
  localparam logic [2:0]  PHASE_D2_DONE = 3'd5;

  localparam logic [8:0]  DIFF_CUTOFF = 9'd15;
  localparam logic [8:0]  DIFF_FINE   = 9'd3;
  localparam logic signed [20:0] SPEED_LIMIT = 21'sd25;

  typedef enum logic [1:0] {
    CLS_CUT    = 2'd0,
    CLS_FINE   = 2'd1,
    CLS_COARSE = 2'd2
  } steer_cls_e;

  typedef struct packed {
    logic [7:0] prop_gain;
    logic [7:0] deriv_gain;
    logic [7:0] target_distance;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_DERIV_GAIN  = 2'd1,
    REG_TARGET_DIST = 2'd2
  } reg_idx_e;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = x * DIV3_RECIP;
    return p[DIV3_SHIFT +: 8];
  endfunction

endpackage

@@ sv/wfpd_front.sv @@
// Front end: converts echo time to centimetres and flags out-of-range readings.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
module wfpd_front (
  input  logic [15:0] echo_i,
  output logic        keep_o,
  output logic [7:0]  cm_o
);
  import wfpd_pkg::*;

  logic [32:0] prod;

  assign prod   = {17'd0, echo_i} * {16'd0, CM_RECIP};
  assign cm_o   = prod[CM_SHIFT +: 8];
  assign keep_o = (echo_i < ECHO_LIMIT);

endmodule

@@ sv/wfpd_queue.sv @@
// Two-entry distance queue between front and back end.
// Depends on nothing.
`timescale 1ns / 1ps
module wfpd_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] pop_data_o
);
  logic [7:0] mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/wfpd_back.sv @@
// Back end: group averaging, PD steering and output register.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
module wfpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wfpd_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  logic [7:0]    q_cm_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [5:0]    out_drive_o,
  output logic [7:0]    out_dist_o
);
  import wfpd_pkg::*;

  logic        en;
  logic [2:0]  phase_q, phase_d;
  logic [9:0]  sum_q, sum_d, sum_new;
  logic [7:0]  d1_q, d1_d;

  logic        s1_vld_q;
  logic [9:0]  s1_sum_q;
  logic [7:0]  s1_d1_q;

  logic        s2_vld_q;
  logic [7:0]  s2_d2_q, s2_d1_q;

  logic        s3_vld_q;
  logic signed [17:0] s3_pd_q, s3_pp_q;
  steer_cls_e  s3_cls_q, cls;
  logic [7:0]  s3_d2_q;

  logic        out_vld_q;
  logic [5:0]  out_dd_q, out_dd_d;
  logic [7:0]  out_dist_q;

  logic signed [8:0]  diff, err;
  logic [8:0]         adiff;
  logic signed [17:0] diff_x, err_x, kd_x, kp_x, pd, pp;
  logic signed [20:0] twice, s;

  assign en      = !out_vld_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;
  assign sum_new = sum_q + {2'd0, q_cm_i};

  // group accumulation
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    d1_d    = d1_q;
    if (q_pop_o) begin
      if (phase_q == PHASE_D1_DONE) begin
        d1_d    = div3(sum_new);
        sum_d   = 10'd0;
        phase_d = phase_q + 3'd1;
      end else if (phase_q == PHASE_D2_DONE) begin
        sum_d   = 10'd0;
        phase_d = 3'd0;
      end else begin
        sum_d   = sum_new;
        phase_d = phase_q + 3'd1;
      end
    end
  end

  // difference, error, gain products and steering class
  always_comb begin
    diff   = $signed({1'b0, s2_d2_q}) - $signed({1'b0, s2_d1_q});
    err    = $signed({1'b0, s2_d2_q}) - $signed({1'b0, cfg_i.target_distance});
    adiff  = diff[8] ? 9'(-diff) : diff;
    diff_x = 18'(diff);
    err_x  = 18'(err);
    kd_x   = $signed({10'd0, cfg_i.deriv_gain});
    kp_x   = $signed({10'd0, cfg_i.prop_gain});
    pd     = kd_x * diff_x;
    pp     = kp_x * err_x;
    if (adiff >= DIFF_CUTOFF) begin
      cls = CLS_CUT;
    end else if (adiff < DIFF_FINE) begin
      cls = CLS_FINE;
    end else begin
      cls = CLS_COARSE;
    end
  end

  // combine per class (coarse halved toward zero, cut forced to zero), saturate
  always_comb begin
    twice = 21'(s3_pd_q) + (21'(s3_pp_q) <<< 2);
    case (s3_cls_q)
      CLS_FINE:   s = 21'(s3_pd_q) + 21'(s3_pp_q);
      CLS_COARSE: s = (twice + $signed({20'd0, twice[20]})) >>> 1;
      default:    s = 21'sd0;
    endcase
    if (s >= SPEED_LIMIT) begin
      out_dd_d = 6'(SPEED_LIMIT);
    end else if (s <= -SPEED_LIMIT) begin
      out_dd_d = 6'(-SPEED_LIMIT);
    end else begin
      out_dd_d = s[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 3'd0;
      sum_q     <= 10'd0;
      d1_q      <= 8'd0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      d1_q    <= d1_d;
      if (en) begin
        s1_vld_q  <= q_pop_o && (phase_q == PHASE_D2_DONE);
        s2_vld_q  <= s1_vld_q;
        s3_vld_q  <= s2_vld_q;
        out_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q   <= sum_new;
      s1_d1_q    <= d1_q;
      s2_d2_q    <= div3(s1_sum_q);
      s2_d1_q    <= s1_d1_q;
      s3_pd_q    <= pd;
      s3_pp_q    <= pp;
      s3_cls_q   <= cls;
      s3_d2_q    <= s2_d2_q;
      out_dd_q   <= out_dd_d;
      out_dist_q <= s3_d2_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_drive_o = out_dd_q;
  assign out_dist_o  = out_dist_q;

endmodule

@@ sv/wall_follow_pd_speed.sv @@
// Top level of the wall follower PD speed block: config registers, front, queue, back.
// Depends on wfpd_pkg, wfpd_front, wfpd_queue, wfpd_back.
//
//  channel   | direction | contents
//  s_axis    | in        | tdata[15:0] echo_us
//  m_axis    | out       | tdata[5:0] drive_difference, [13:6] latest_distance
//  cfg       | in        | index 0 prop_gain, 1 deriv_gain, 2 target_distance
//
// One request per cycle while the queue is not full; the front converts combinationally.
// After its sixth distance leaves the queue, a result moves through the sum, divide,
// multiply and combine/saturate registers, the last being the output register.
// Reset clears all control state and loads gains 1/6, setpoint 0; no clearing pass.
// A stalled m_axis holds the back pipeline; the two-entry queue then fills
// and drops s_axis_tready_o.
`timescale 1ns / 1ps
module wall_follow_pd_speed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] echo_us
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [5:0] drive_difference, [13:6] latest_distance
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import wfpd_pkg::*;

  cfg_t       cfg_q;
  logic       keep;
  logic [7:0] cm;
  logic       q_full, q_valid, q_pop;
  logic [7:0] q_cm;
  logic [5:0] drive;
  logic [7:0] latest_cm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= 8'd1;
      cfg_q.deriv_gain      <= 8'd6;
      cfg_q.target_distance <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PROP_GAIN:   cfg_q.prop_gain       <= cfg_data_i;
        REG_DERIV_GAIN:  cfg_q.deriv_gain      <= cfg_data_i;
        REG_TARGET_DIST: cfg_q.target_distance <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !q_full;

  wfpd_front u_front (
    .echo_i (s_axis_tdata_i),
    .keep_o (keep),
    .cm_o   (cm)
  );

  wfpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i && keep),
    .push_data_i (cm),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cm)
  );

  wfpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cm_i      (q_cm),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_drive_o (drive),
    .out_dist_o  (latest_cm)
  );

  assign m_axis_tdata_o = {2'd0, latest_cm, drive};

endmodule

@@ sv/wfpd_checker.sv @@
// Port-level checker for wall_follow_pd_speed, bound to the top level.
// Depends on wall_follow_pd_speed_defines.svh.
`timescale 1ns / 1ps
`include "wall_follow_pd_speed_defines.svh"
module wfpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  logic signed [5:0] drive;
  logic [7:0]        latest;

  assign drive  = $signed(m_axis_tdata_o[5:0]);
  assign latest = m_axis_tdata_o[13:6];

  `WFPD_ASSERT_NOW(a_drive_range, m_axis_tvalid_o, (drive <= 6'sd25) && (drive >= -6'sd25))
  `WFPD_ASSERT_NOW(a_dist_range, m_axis_tvalid_o, (latest <= 8'd250) && (m_axis_tdata_o[15:14] == 2'd0))
  `WFPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `WFPD_ASSERT_NEXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))

endmodule

bind wall_follow_pd_speed wfpd_checker u_wfpd_checker (.*);
